[design/serial_chain_forward_kinematics_unit_macros.svh]
// Assertion macros for the serial chain forward kinematics unit.
// Included by the modules that assert; no other dependencies.
`ifndef SERIAL_CHAIN_FORWARD_KINEMATICS_UNIT_MACROS_SVH
`define SERIAL_CHAIN_FORWARD_KINEMATICS_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define SCFK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define SCFK_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SCFK_ASSERT(label, clk, rst_n, prop)
`define SCFK_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[design/scfk_pkg.sv]
// Shared constants, types and functions of the forward kinematics unit.
// No dependencies.
package scfk_pkg;

    localparam int MAX_JOINTS   = 32;
    localparam int CORDIC_STEPS = 16;
    localparam int JCNT_W       = $clog2(MAX_JOINTS);
    localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

    localparam logic [1:0] REG_CHAIN_TYPE = 2'd0;
    localparam logic [1:0] REG_HALF_LEN   = 2'd1;
    localparam logic [1:0] REG_IN_TO_JNT  = 2'd2;
    localparam logic [1:0] REG_JNT_TO_OUT = 2'd3;

    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] INV_GAIN    = 34'sd652032874;
    localparam logic signed [17:0] ONE_Q16     = 18'sd65536;

    typedef logic signed [17:0] t_rot;
    typedef logic signed [31:0] t_off;

    typedef struct packed {
        logic              start;
        logic signed [15:0] angle;
    } t_cordic_req;

    typedef struct packed {
        logic done;
        t_rot sin_v;
        t_rot cos_v;
    } t_cordic_rsp;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] v;
        unique case (i)
            5'd0: v = 34'sd843314856;   5'd1: v = 34'sd497837829;
            5'd2: v = 34'sd263043836;   5'd3: v = 34'sd133525158;
            5'd4: v = 34'sd67021686;    5'd5: v = 34'sd33543515;
            5'd6: v = 34'sd16775850;    5'd7: v = 34'sd8388437;
            5'd8: v = 34'sd4194282;     5'd9: v = 34'sd2097149;
            5'd10: v = 34'sd1048575;    5'd11: v = 34'sd524287;
            5'd12: v = 34'sd262143;     5'd13: v = 34'sd131071;
            5'd14: v = 34'sd65535;      5'd15: v = 34'sd32767;
            5'd16: v = 34'sd16383;      5'd17: v = 34'sd8191;
            5'd18: v = 34'sd4095;       5'd19: v = 34'sd2047;
            5'd20: v = 34'sd1023;       5'd21: v = 34'sd511;
            5'd22: v = 34'sd255;        5'd23: v = 34'sd127;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

[design/scfk_if.sv]
// Valid/ready channel interfaces for joints, rows and configuration writes.
// Depends on nothing.
interface scfk_joint_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] joint_angle;
    logic               last_joint;
    modport source (output valid, joint_angle, last_joint, input ready);
    modport sink (input valid, joint_angle, last_joint, output ready);
endinterface

interface scfk_row_if;
    logic               valid;
    logic               ready;
    logic [5:0]         module_index;
    logic [1:0]         row_index;
    logic signed [17:0] col_x;
    logic signed [17:0] col_y;
    logic signed [17:0] col_z;
    logic signed [31:0] offset;
    logic               last_row;
    logic               chain_end;
    modport source (output valid, module_index, row_index, col_x, col_y, col_z, offset,
                    last_row, chain_end, input ready);
    modport sink (input valid, module_index, row_index, col_x, col_y, col_z, offset,
                  last_row, chain_end, output ready);
endinterface

interface scfk_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[design/scfk_cordic.sv]
// Iterative CORDIC sine/cosine, one rotation step per cycle.
// Depends on scfk_pkg and the assertion macro header.
`include "serial_chain_forward_kinematics_unit_macros.svh"
module scfk_cordic
    import scfk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cordic_req i_req,
    output t_cordic_rsp o_rsp
);
    logic signed [33:0] r_x, r_y, r_z, n_x, n_y, n_z;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_busy, n_busy, r_flip, n_flip, r_done, n_done;
    t_rot               r_sin, r_cos, n_sin, n_cos;
    logic signed [33:0] z0, xr, yr;
    logic signed [20:0] xs, ys;

    function automatic t_rot fin(input logic signed [33:0] v, input logic flip);
        logic signed [20:0] s;
        t_rot c;
        s = 21'((v + 34'sd8192) >>> 14);
        if (s > 21'sd65536) c = ONE_Q16;
        else if (s < -21'sd65536) c = -ONE_Q16;
        else c = s[17:0];
        return flip ? -c : c;
    endfunction

    always_comb begin
        n_x = r_x; n_y = r_y; n_z = r_z; n_step = r_step; n_busy = r_busy;
        n_flip = r_flip; n_done = 1'b0; n_sin = r_sin; n_cos = r_cos;
        z0 = 34'(i_req.angle) <<< 17;
        xr = r_x >>> r_step; yr = r_y >>> r_step;
        xs = '0; ys = '0;
        if (i_req.start) begin
            n_busy = 1'b1; n_step = '0; n_x = INV_GAIN; n_y = '0; n_flip = 1'b0; n_z = z0;
            if (z0 > HALF_PI_Q30) begin
                n_z = z0 - PI_Q30; n_flip = 1'b1;
            end else if (z0 < -HALF_PI_Q30) begin
                n_z = z0 + PI_Q30; n_flip = 1'b1;
            end
        end else if (r_busy) begin
            if (r_step == STEP_W'(CORDIC_STEPS)) begin
                n_busy = 1'b0; n_done = 1'b1;
                n_sin = fin(r_y, r_flip); n_cos = fin(r_x, r_flip);
            end else begin
                if (!r_z[33]) begin
                    n_x = r_x - yr; n_y = r_y + xr; n_z = r_z - atan_q30(5'(r_step));
                end else begin
                    n_x = r_x + yr; n_y = r_y - xr; n_z = r_z + atan_q30(5'(r_step));
                end
                n_step = r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_flip <= n_flip;
        r_sin <= n_sin; r_cos <= n_cos; r_step <= n_step;
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
    end

    assign o_rsp = '{done: r_done, sin_v: r_sin, cos_v: r_cos};

    `SCFK_ASSERT(a_done_after_busy, i_clk, i_rst_n, r_done |-> $past(r_busy))
    `SCFK_ASSERT(a_step_bound, i_clk, i_rst_n, r_busy |-> r_step <= STEP_W'(CORDIC_STEPS))
    `SCFK_ASSERT(a_no_done_busy, i_clk, i_rst_n, !(r_done && r_busy))
endmodule

[design/scfk_mac.sv]
// Shared multiply-accumulate unit: one 18x33 product per cycle into a wide sum.
// Depends on scfk_pkg.
module scfk_mac
    import scfk_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_clr,
    input  logic               i_en,
    input  logic signed [17:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [55:0] o_acc
);
    logic signed [50:0] r_prod;
    logic               r_vld;
    logic signed [55:0] r_acc, n_acc;

    // register the product, then accumulate
    always_comb begin
        n_acc = r_acc;
        if (i_clr) n_acc = '0;
        else if (r_vld) n_acc = r_acc + 56'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_vld  <= i_en;
        r_acc  <= n_acc;
    end

    assign o_acc = r_acc;
endmodule

[design/serial_chain_forward_kinematics_unit.sv]
// Serial chain forward kinematics: joint angles in, frame rows out.
// Uses the CORDIC unit and the shared multiply-accumulate unit.
// Channels: i_joint carries one joint angle (Q3.13) and a tail flag per
// transfer; o_row returns three transfers per joint, rows 0..2 of the new
// running frame: rotation row (Q1.16) and translation (Q16.16, saturated).
// The user must write the four configuration registers over i_cfg only
// while the block is idle; the block does not enforce this. A joint takes
// these steps in order: start the CORDIC unit, its 16 CORDIC steps,
// rounding and hand-over, two length products, then twelve sums (nine
// rotation entries, three offsets) of three products each through the single
// shared multiplier, each sum issuing its three products and then flushing
// the product register and the accumulator, and three row transfers.
// The block accepts no joint while a joint is in work or a row still waits;
// o_row.valid holds until the receiver takes each row, so a stalled
// receiver simply stalls the sequencer.
// Reset returns the frame to identity, the joint count to zero and the
// registers to their reset values; after the tail joint, or the joint
// numbered MAX_JOINTS-1, the frame goes back to identity for the next chain.
`include "serial_chain_forward_kinematics_unit_macros.svh"
module serial_chain_forward_kinematics_unit
    import scfk_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    scfk_joint_if.sink  i_joint,
    scfk_cfg_if.sink    i_cfg,
    scfk_row_if.source  o_row
);
    localparam logic [2:0] S_IDLE = 3'd0, S_TRIG = 3'd1, S_LEN = 3'd2,
                           S_MAC = 3'd3, S_EMIT = 3'd4;

    logic [2:0]        r_state, n_state;
    logic              r_type;
    logic [23:0]       r_half, r_in2j, r_j2o;
    t_rot              r_rot [9];
    t_off              r_off [3];
    t_rot              r_nrot [9];
    t_off              r_noff [3];
    logic [JCNT_W-1:0] r_jcnt;
    logic              r_tail;
    logic signed [15:0] r_angle;
    t_rot              r_sin, r_cos;
    logic signed [32:0] r_p [3];
    logic [3:0]        r_out;      // output entry: 0..8 rotation, 9..11 offsets
    logic [2:0]        r_term;     // product term within a sum, 0..2 issue, 3..4 flush
    logic [1:0]        r_emit;
    logic              r_lenph;

    t_cordic_req cq;
    t_cordic_rsp cr;
    logic               mclr, men;
    logic signed [17:0] ma;
    logic signed [32:0] mb;
    logic signed [55:0] macc;

    scfk_cordic u_cordic (.i_clk, .i_rst_n, .i_req(cq), .o_rsp(cr));
    scfk_mac u_mac (.i_clk, .i_clr(mclr), .i_en(men), .i_a(ma), .i_b(mb), .o_acc(macc));

    // relative rotation entry j,k for current joint
    function automatic t_rot rel(input logic ty, input logic odd, input t_rot s,
                                 input t_rot c, input logic [3:0] idx);
        t_rot v;
        v = '0;
        if (!ty) begin
            unique case (idx)
                4'd1: v = ONE_Q16; 4'd3: v = -c; 4'd5: v = s;
                4'd6: v = s; 4'd8: v = c;
                default: v = '0;
            endcase
        end else if (!odd) begin
            unique case (idx)
                4'd0: v = ONE_Q16; 4'd4: v = c; 4'd5: v = s;
                4'd7: v = -s; 4'd8: v = c;
                default: v = '0;
            endcase
        end else begin
            unique case (idx)
                4'd0: v = c; 4'd2: v = -s; 4'd4: v = ONE_Q16;
                4'd6: v = s; 4'd8: v = c;
                default: v = '0;
            endcase
        end
        return v;
    endfunction

    logic [1:0] ro, co, tj;
    logic [3:0] fidx, ridx;
    logic signed [17:0] sc_sel;
    logic signed [40:0] rnd;
    logic signed [39:0] lenr;
    t_rot               rot_sat;
    logic signed [56:0] offs;
    t_off               off_sat;
    logic               jodd;

    assign jodd = r_jcnt[0];
    assign cq.angle = r_angle;
    assign cq.start = (r_state == S_TRIG);

    always_comb begin
        // row of the output entry, then its column
        unique case (r_out)
            4'd0, 4'd1, 4'd2: ro = 2'd0;
            4'd3, 4'd4, 4'd5: ro = 2'd1;
            default:          ro = 2'd2;
        endcase
        co = 2'(r_out - 4'(ro) * 4'd3);
        tj = r_term[1:0];
        if (r_out < 4'd9) begin
            fidx = 4'(ro) * 4'd3 + 4'(tj);
            ridx = 4'(tj) * 4'd3 + 4'(co);
        end else begin
            fidx = 4'(r_out - 4'd9) * 4'd3 + 4'(tj);
            ridx = '0;
        end
        sc_sel = r_lenph ? r_cos : r_sin;
        mclr = 1'b0; men = 1'b0; ma = '0; mb = '0;
        if (r_state == S_LEN && !r_cwait && r_term < 3'd1) begin
            men = 1'b1; ma = sc_sel; mb = 33'(signed'({1'b0, r_type ? r_in2j : r_half}));
        end else if (r_state == S_MAC && r_term < 3'd3) begin
            men = 1'b1; ma = r_rot[fidx];
            mb = (r_out < 4'd9) ? 33'(rel(r_type, jodd, r_sin, r_cos, ridx)) : r_p[tj];
        end
        if ((r_state == S_LEN || r_state == S_MAC) && r_term == 3'd4) mclr = 1'b1;
        if (r_state == S_TRIG) mclr = 1'b1;
        rnd = 41'((macc + 56'sd32768) >>> 16);
        lenr = 40'(rnd);
        if (rnd > 41'sd131071) rot_sat = 18'sd131071;
        else if (rnd < -41'sd131072) rot_sat = -18'sd131072;
        else rot_sat = rnd[17:0];
        offs = 57'(rnd) + 57'(r_off[2'(r_out - 4'd9)]);
        if (offs > 57'sd2147483647) off_sat = 32'sh7fffffff;
        else if (offs < -57'sd2147483648) off_sat = 32'sh80000000;
        else off_sat = offs[31:0];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_joint.valid) n_state = S_TRIG;
            S_TRIG: n_state = S_LEN;
            S_LEN:  if (r_lenph && r_term == 3'd4 && cr.done == 1'b0 && r_out == 4'd0)
                        n_state = S_MAC;
            S_MAC:  if (r_out == 4'd11 && r_term == 3'd4) n_state = S_EMIT;
            S_EMIT: if (o_row.ready && r_emit == 2'd2) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic r_cwait;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_type <= 1'b0; r_half <= 24'd1673;
            r_in2j <= 24'd94437; r_j2o <= 24'd70451; r_jcnt <= '0;
            for (int k = 0; k < 9; k++) r_rot[k] <= (k % 4 == 0) ? ONE_Q16 : '0;
            for (int k = 0; k < 3; k++) r_off[k] <= '0;
            r_cwait <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    REG_CHAIN_TYPE: r_type <= i_cfg.data[0];
                    REG_HALF_LEN:   r_half <= i_cfg.data;
                    REG_IN_TO_JNT:  r_in2j <= i_cfg.data;
                    REG_JNT_TO_OUT: r_j2o <= i_cfg.data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: if (i_joint.valid) begin
                    r_angle <= i_joint.joint_angle;
                    r_tail <= i_joint.last_joint || (r_jcnt == JCNT_W'(MAX_JOINTS - 1));
                end
                S_TRIG: begin r_cwait <= 1'b1; r_lenph <= 1'b0; r_term <= '0; r_out <= '0; end
                S_LEN: begin
                    if (cr.done) begin
                        r_sin <= cr.sin_v; r_cos <= cr.cos_v; r_cwait <= 1'b0;
                    end else if (!r_cwait) begin
                        if (r_term == 3'd4) begin
                            r_term <= '0;
                            r_lenph <= 1'b1;
                            if (!r_type) begin
                                if (!r_lenph) begin
                                    r_p[0] <= '0; r_p[1] <= 33'(-lenr);
                                end else
                                    r_p[2] <= 33'(-lenr - 40'(r_half));
                            end else if (!jodd) begin
                                if (!r_lenph) begin
                                    r_p[0] <= '0; r_p[1] <= 33'(-lenr);
                                end else
                                    r_p[2] <= 33'(-lenr - 40'(r_j2o));
                            end else begin
                                if (!r_lenph) begin
                                    r_p[0] <= 33'(lenr); r_p[1] <= '0;
                                end else
                                    r_p[2] <= 33'(-lenr - 40'(r_j2o));
                            end
                        end else r_term <= r_term + 1'b1;
                    end
                end
                S_MAC: begin
                    if (r_term == 3'd4) begin
                        r_term <= '0;
                        if (r_out < 4'd9) r_nrot[r_out] <= rot_sat;
                        else r_noff[2'(r_out - 4'd9)] <= off_sat;
                        r_out <= r_out + 1'b1;
                        if (r_out == 4'd11) r_emit <= '0;
                    end else r_term <= r_term + 1'b1;
                end
                S_EMIT: if (o_row.ready) begin
                    r_emit <= r_emit + 1'b1;
                    if (r_emit == 2'd2) begin
                        if (r_tail) begin
                            r_jcnt <= '0;
                            for (int k = 0; k < 9; k++) r_rot[k] <= (k % 4 == 0) ? ONE_Q16 : '0;
                            for (int k = 0; k < 3; k++) r_off[k] <= '0;
                        end else begin
                            r_jcnt <= r_jcnt + 1'b1;
                            r_rot <= r_nrot; r_off <= r_noff;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign i_joint.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_row.valid = (r_state == S_EMIT);
    assign o_row.module_index = 6'(7'(r_jcnt) + 7'd1);
    assign o_row.row_index = r_emit;
    assign o_row.col_x = r_nrot[4'(r_emit) * 4'd3];
    assign o_row.col_y = r_nrot[4'(r_emit) * 4'd3 + 4'd1];
    assign o_row.col_z = r_nrot[4'(r_emit) * 4'd3 + 4'd2];
    assign o_row.offset = r_noff[r_emit];
    assign o_row.last_row = (r_emit == 2'd2);
    assign o_row.chain_end = r_tail;

    `SCFK_ASSERT(a_one_side, i_clk, i_rst_n, !(i_joint.ready && o_row.valid))
    `SCFK_ASSERT(a_emit_row, i_clk, i_rst_n, o_row.valid |-> r_emit != 2'd3)
    `SCFK_ASSERT(a_mac_range, i_clk, i_rst_n, (r_state == S_MAC) |-> r_out < 4'd12)
endmodule

[bench/serial_chain_forward_kinematics_unit_tb.sv]
// Testbench for the serial chain forward kinematics unit: joint angles in, frame rows out.
// Predicts each frame row in a bit-true chain model and checks every row transfer.
// Depends on scfk_pkg, the channel interfaces in scfk_if.sv and the unit's RTL.
module serial_chain_forward_kinematics_unit_tb;
    import scfk_pkg::*;

    localparam int  CLK_HALF   = 6;
    localparam int  CYCLE_CAP  = 600000;
    localparam int  DRAIN_WAIT = 80;
    localparam longint ROT_ONE = 65536;

    typedef struct {
        logic [5:0]  module_index;
        logic [1:0]  row_index;
        logic [17:0] col_x;
        logic [17:0] col_y;
        logic [17:0] col_z;
        logic [31:0] offset;
        logic        last_row;
        logic        chain_end;
    } t_frame_row;

    logic i_clk;
    logic i_rst_n;

    scfk_joint_if jif();
    scfk_cfg_if   cif();
    scfk_row_if   rif();

    serial_chain_forward_kinematics_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_joint (jif),
        .i_cfg   (cif),
        .o_row   (rif)
    );

    // Chain model state
    logic        chain_type_q;
    logic [23:0] half_len_q;
    logic [23:0] in_to_jnt_q;
    logic [23:0] jnt_to_out_q;
    longint      frame_rot[9];
    longint      frame_off[3];
    int          joints_done;

    t_frame_row  rows_q[$];
    int          mismatches;
    int          cycles;
    bit          steady_ready;

    longint arctan_tbl[24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127
    };

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // CORDIC sine and cosine in Q1.16 from a Q3.13 angle
    task automatic joint_sincos(input logic signed [15:0] ang, output longint s, output longint c);
        longint z, x, y, nx;
        bit     flip;
        z = longint'(ang) * 131072;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 64'sd1686629713) begin
            z = z - 64'sd3373259426;
            flip = 1;
        end else if (z < -64'sd1686629713) begin
            z = z + 64'sd3373259426;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - arctan_tbl[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + arctan_tbl[i];
            end
            x = nx;
        end
        x = sat((x + 8192) >>> 14, -ROT_ONE, ROT_ONE);
        y = sat((y + 8192) >>> 14, -ROT_ONE, ROT_ONE);
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endtask

    function automatic longint len_times(logic [23:0] len, longint v);
        return (longint'(len) * v + 32768) >>> 16;
    endfunction

    function automatic void frame_to_identity();
        for (int k = 0; k < 9; k++)
            frame_rot[k] = (k % 4 == 0) ? ROT_ONE : 0;
        for (int k = 0; k < 3; k++)
            frame_off[k] = 0;
    endfunction

    // Advance the chain by one joint and queue its three frame rows
    task automatic chain_advance(input logic signed [15:0] ang, input logic tail_in);
        longint s, c, rel[9], tr[3], nrot[9], noff[3], sum, acc;
        logic   tail;
        t_frame_row fr;
        tail = tail_in;
        joint_sincos(ang, s, c);
        for (int k = 0; k < 9; k++)
            rel[k] = 0;
        if (chain_type_q == 1'b0) begin
            rel[1] = ROT_ONE;
            rel[3] = -c; rel[5] = s;
            rel[6] = s;  rel[8] = c;
            tr[0] = 0;
            tr[1] = -len_times(half_len_q, s);
            tr[2] = -len_times(half_len_q, c) - longint'(half_len_q);
        end else if (joints_done % 2 == 0) begin
            rel[0] = ROT_ONE;
            rel[4] = c;  rel[5] = s;
            rel[7] = -s; rel[8] = c;
            tr[0] = 0;
            tr[1] = -len_times(in_to_jnt_q, s);
            tr[2] = -len_times(in_to_jnt_q, c) - longint'(jnt_to_out_q);
        end else begin
            rel[0] = c;  rel[2] = -s;
            rel[4] = ROT_ONE;
            rel[6] = s;  rel[8] = c;
            tr[0] = len_times(in_to_jnt_q, s);
            tr[1] = 0;
            tr[2] = -len_times(in_to_jnt_q, c) - longint'(jnt_to_out_q);
        end
        for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) begin
                sum = 0;
                for (int j = 0; j < 3; j++)
                    sum += frame_rot[r*3+j] * rel[j*3+k];
                nrot[r*3+k] = sat((sum + 32768) >>> 16, -131072, 131071);
                acc += frame_rot[r*3+k] * tr[k];
            end
            noff[r] = sat(((acc + 32768) >>> 16) + frame_off[r],
                          -64'sd2147483648, 64'sd2147483647);
        end
        frame_rot = nrot;
        frame_off = noff;
        if (joints_done + 1 >= MAX_JOINTS)
            tail = 1'b1;
        for (int r = 0; r < 3; r++) begin
            fr.module_index = 6'(joints_done + 1);
            fr.row_index    = 2'(r);
            fr.col_x        = 18'(nrot[r*3]);
            fr.col_y        = 18'(nrot[r*3+1]);
            fr.col_z        = 18'(nrot[r*3+2]);
            fr.offset       = 32'(noff[r]);
            fr.last_row     = (r == 2);
            fr.chain_end    = tail;
            rows_q.push_back(fr);
        end
        if (tail) begin
            frame_to_identity();
            joints_done = 0;
        end else begin
            joints_done++;
        end
    endtask

    // Row receiver: random stalls, mostly short, a few long
    initial begin
        int hold;
        logic rdy;
        hold = 0;
        rdy = 1'b0;
        rif.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (steady_ready) begin
                rdy = 1'b1;
            end else if (hold == 0) begin
                int r;
                r = $urandom_range(0, 9);
                if (r < 6) begin
                    rdy = 1'b1;
                    hold = $urandom_range(1, 8);
                end else if (r < 9) begin
                    rdy = 1'b0;
                    hold = $urandom_range(1, 3);
                end else begin
                    rdy = 1'b0;
                    hold = $urandom_range(10, 40);
                end
            end else begin
                hold--;
            end
            rif.ready <= rdy;
        end
    end

    // Check each row transfer against the oldest predicted row
    always @(posedge i_clk) begin
        if (i_rst_n && rif.valid && rif.ready) begin
            if (rows_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected row: module %0d row %0d", rif.module_index,
                             rif.row_index);
            end else begin
                t_frame_row e;
                e = rows_q.pop_front();
                if (rif.module_index !== e.module_index || rif.row_index !== e.row_index ||
                    rif.col_x !== e.col_x || rif.col_y !== e.col_y ||
                    rif.col_z !== e.col_z || rif.offset !== e.offset ||
                    rif.last_row !== e.last_row || rif.chain_end !== e.chain_end) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("row mismatch exp: m%0d r%0d %h %h %h off %h lr%b ce%b",
                                 e.module_index, e.row_index, e.col_x, e.col_y, e.col_z,
                                 e.offset, e.last_row, e.chain_end);
                        $display("             got: m%0d r%0d %h %h %h off %h lr%b ce%b",
                                 rif.module_index, rif.row_index, rif.col_x, rif.col_y,
                                 rif.col_z, rif.offset, rif.last_row, rif.chain_end);
                    end
                end
            end
        end
    end

    // Send one joint; valid stays high when the next joint follows with no gap
    task automatic send_joint(input logic signed [15:0] ang, input logic tail);
        int gap;
        @(negedge i_clk);
        gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        if (steady_ready)
            gap = 0;
        if (gap > 0) begin
            jif.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        jif.joint_angle <= ang;
        jif.last_joint  <= tail;
        jif.valid       <= 1'b1;
        @(posedge i_clk);
        while (!jif.ready) @(posedge i_clk);
        chain_advance(ang, tail);
    endtask

    // Drop joint valid and wait for every predicted row to arrive
    task automatic drain_rows();
        @(negedge i_clk);
        jif.valid <= 1'b0;
        while (rows_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        @(negedge i_clk);
        cif.index <= idx;
        cif.data  <= val;
        cif.valid <= 1'b1;
        @(posedge i_clk);
        while (!cif.ready) @(posedge i_clk);
        case (idx)
            REG_CHAIN_TYPE: chain_type_q = val[0];
            REG_HALF_LEN:   half_len_q   = val;
            REG_IN_TO_JNT:  in_to_jnt_q  = val;
            REG_JNT_TO_OUT: jnt_to_out_q = val;
        endcase
    endtask

    // Write all four registers; the chain must be drained
    task automatic set_chain(input logic ctype, input logic [23:0] h, input logic [23:0] ij,
                             input logic [23:0] jo);
        write_reg(REG_CHAIN_TYPE, {23'd0, ctype});
        write_reg(REG_HALF_LEN, h);
        write_reg(REG_IN_TO_JNT, ij);
        write_reg(REG_JNT_TO_OUT, jo);
        @(negedge i_clk);
        cif.valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_angle();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'sh7fff;
        if (r == 1)
            return 16'sh8000;
        return 16'($urandom);
    endfunction

    // Default registers, angle extremes and the quarter/half turn boundaries
    task automatic test_default_half_modules();
        send_joint(16'sd0, 1'b0);
        send_joint(16'sh7fff, 1'b0);
        send_joint(16'sh8000, 1'b0);
        send_joint(16'sd12868, 1'b0);
        send_joint(-16'sd12868, 1'b0);
        send_joint(16'sd12867, 1'b0);
        send_joint(-16'sd12867, 1'b0);
        send_joint(16'sd25736, 1'b0);
        send_joint(-16'sd1, 1'b1);
        send_joint(16'sd1, 1'b1);
        drain_rows();
    endtask

    // Alternating joints at the length extremes, with odd and even positions
    task automatic test_alternating_extremes();
        set_chain(1'b1, 24'hffffff, 24'hffffff, 24'hffffff);
        send_joint(16'sd6434, 1'b0);
        send_joint(-16'sd6434, 1'b0);
        send_joint(16'sh7fff, 1'b0);
        send_joint(16'sh8000, 1'b1);
        drain_rows();
        set_chain(1'b1, 24'd0, 24'd0, 24'd0);
        send_joint(16'sd3000, 1'b0);
        send_joint(16'sd9000, 1'b1);
        drain_rows();
    endtask

    // Chain that never flags its tail: the last allowed joint ends it
    task automatic test_chain_overrun();
        set_chain(1'b0, 24'hffffff, 24'd94437, 24'd70451);
        for (int k = 0; k < MAX_JOINTS + 2; k++)
            send_joint(rand_angle(), 1'b0);
        send_joint(rand_angle(), 1'b1);
        drain_rows();
    endtask

    // Random chains under random register settings
    task automatic test_random_chains(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            if (sent % 50 == 0) begin
                drain_rows();
                set_chain(1'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
                steady_ready = ($urandom_range(0, 3) == 0);
            end
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 36);
            for (int k = 0; k < len && sent < n_items; k++) begin
                send_joint(rand_angle(), (k == len - 1) || ($urandom_range(0, 19) == 0));
                sent++;
            end
        end
        steady_ready = 0;
        drain_rows();
    endtask

    initial begin
        mismatches   = 0;
        cycles       = 0;
        steady_ready = 0;
        jif.valid = 1'b0;
        jif.joint_angle = '0;
        jif.last_joint = 1'b0;
        cif.valid = 1'b0;
        cif.index = REG_CHAIN_TYPE;
        cif.data = '0;
        chain_type_q = 1'b0;
        half_len_q   = 24'd1673;
        in_to_jnt_q  = 24'd94437;
        jnt_to_out_q = 24'd70451;
        joints_done  = 0;
        frame_to_identity();
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_half_modules();
        test_alternating_extremes();
        test_chain_overrun();
        test_random_chains(180);

        if (mismatches == 0 && rows_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+design
design/scfk_pkg.sv
design/scfk_if.sv
design/scfk_cordic.sv
design/scfk_mac.sv
design/serial_chain_forward_kinematics_unit.sv
bench/serial_chain_forward_kinematics_unit_tb.sv
